// ----- hdl/irts_pkg.sv -----
// Shared types, constants and a helper function for the IP range table search unit.
package irts_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
	localparam int IDX_W         = 12;
	localparam int ADDR_W        = 32;
	localparam int OFS_W         = 24;
	localparam int CFG_IDX_W     = 2;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENTRY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_ENTRY  = CFG_IDX_W'(1);

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] entry_range_start;
		logic [OFS_W-1:0]  entry_record_offset;
		logic [ADDR_W-1:0] lookup_address;
		logic [IDX_W-1:0]  lower_limit;
		logic [IDX_W-1:0]  upper_limit;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]  found_index;
		logic [ADDR_W-1:0] found_range_start;
		logic [OFS_W-1:0]  found_record_offset;
		logic              bad_span;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] range_start;
		logic [OFS_W-1:0]  record_offset;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [TBL_AW-1:0] rd_addr;
		logic              wr_en;
		logic [TBL_AW-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_entry;
		logic [IDX_W-1:0] last_entry;
	} cfg_t;

	typedef struct packed {
		logic              init;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] hdr;
		logic [IDX_W-1:0]  left;
		logic [IDX_W-1:0]  right;
		logic [IDX_W-1:0]  mid;
	} step_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] mid;
		logic             more;
	} step_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_STEP,
		ST_RESULT
	} state_t;

	// Table positions wrap at the table size.
	function automatic logic [TBL_AW-1:0] slot_of(input logic [IDX_W-1:0] i);
		slot_of = TBL_AW'(i % TABLE_ENTRIES);
	endfunction

endpackage

// ----- hdl/ip_range_table_search_unit.sv -----
// Top level: configuration registers, index table and search sequencer.
// A write transaction writes the table as it is taken and yields no result.
// A lookup reads one table entry in the start state and one in each search step, one per cycle
// on the single table read port, and then loads its result once the output can take it.
// A reversed span skips the search steps, reads the lower bound entry and loads its result;
// the next transaction is taken in the cycle after the load.
// Reset clears the sequencer, the result valid and both bounds to zero; table contents
// stay undefined until written and need no clearing pass.
module ip_range_table_search_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [irts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irts_pkg::IDX_W-1:0]       cfg_data,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  irts_pkg::cmd_t                   cmd,
	output logic                             res_valid,
	input  logic                             res_stall,
	output irts_pkg::rsp_t                   res
);

	irts_pkg::cfg_t     cfg_q;
	irts_pkg::mem_req_t mreq;
	irts_pkg::entry_t   rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				irts_pkg::CFG_FIRST_ENTRY: begin
					cfg_q.first_entry <= cfg_data;
				end
				irts_pkg::CFG_LAST_ENTRY: begin
					cfg_q.last_entry <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	irts_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.mreq      (mreq),
		.rd_data   (rd_data)
	);

	irts_table u_table (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

endmodule

// ----- hdl/irts_table.sv -----
// Index table memory: one write port and one registered read port.
module irts_table (
	input  logic              clk,
	input  irts_pkg::mem_req_t req,
	output irts_pkg::entry_t  rd_data
);

	irts_pkg::entry_t mem_q [irts_pkg::TABLE_ENTRIES];
	irts_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		// Read data holds between reads so a waiting result keeps its entry.
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- hdl/irts_step.sv -----
// Shared search step unit: one unsigned address compare, span update and midpoint.
module irts_step (
	input  irts_pkg::step_in_t  si,
	output irts_pkg::step_out_t so
);

	logic [irts_pkg::IDX_W-1:0] left_n;
	logic [irts_pkg::IDX_W-1:0] right_n;
	logic [irts_pkg::IDX_W-1:0] span;
	logic                       below;

	always_comb begin
		below = si.addr < si.hdr;
		if (si.init) begin
			left_n  = si.left;
			right_n = si.right;
		end else if (below) begin
			left_n  = si.left;
			right_n = si.mid;
		end else begin
			left_n  = si.mid;
			right_n = si.right;
		end
		// The span wraps only on a reversed span, which is not searched; elsewhere left stays at or below right.
		span     = right_n - left_n;
		so.left  = left_n;
		so.right = right_n;
		so.mid   = left_n + (span >> 1);
		so.more  = left_n < so.mid;
	end

endmodule

// ----- hdl/irts_search.sv -----
// Search sequencer: takes transactions, writes the table and steps the binary search.
module irts_search (
	input  logic                clk,
	input  logic                arst_n,
	input  irts_pkg::cfg_t      cfg,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  irts_pkg::cmd_t      cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output irts_pkg::rsp_t      res,
	output irts_pkg::mem_req_t  mreq,
	input  irts_pkg::entry_t    rd_data
);

	irts_pkg::state_t state_q;
	irts_pkg::state_t state_d;
	irts_pkg::cmd_t   cmd_q;
	irts_pkg::rsp_t   res_q;
	logic             res_valid_q;

	logic [irts_pkg::IDX_W-1:0] left_q;
	logic [irts_pkg::IDX_W-1:0] right_q;
	logic [irts_pkg::IDX_W-1:0] mid_q;
	logic                       bad_q;

	logic [irts_pkg::IDX_W-1:0] lo_r;
	logic [irts_pkg::IDX_W-1:0] hi_r;
	logic                       bad_r;
	logic                       accept;
	logic                       load;

	irts_pkg::step_in_t  si;
	irts_pkg::step_out_t so;

	irts_step u_step (
		.si (si),
		.so (so)
	);

	assign cmd_stall = (state_q != irts_pkg::ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign load      = (state_q == irts_pkg::ST_RESULT) && (!res_valid_q || !res_stall);

	// A zero limit selects the configured table bound.
	assign lo_r  = (cmd_q.lower_limit == '0) ? cfg.first_entry : cmd_q.lower_limit;
	assign hi_r  = (cmd_q.upper_limit == '0) ? cfg.last_entry : cmd_q.upper_limit;
	assign bad_r = hi_r < lo_r;

	always_comb begin
		state_d = state_q;
		case (state_q)
			irts_pkg::ST_IDLE: begin
				if (accept && cmd.kind == irts_pkg::KIND_LOOKUP) begin
					state_d = irts_pkg::ST_START;
				end
			end
			irts_pkg::ST_START: begin
				state_d = bad_r ? irts_pkg::ST_RESULT : irts_pkg::ST_STEP;
			end
			irts_pkg::ST_STEP: begin
				state_d = so.more ? irts_pkg::ST_STEP : irts_pkg::ST_RESULT;
			end
			irts_pkg::ST_RESULT: begin
				if (load) begin
					state_d = irts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = irts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mreq     = '0;
		si.init  = 1'b1;
		si.addr  = cmd_q.lookup_address;
		si.hdr   = rd_data.range_start;
		si.left  = lo_r;
		si.right = hi_r;
		si.mid   = mid_q;
		case (state_q)
			irts_pkg::ST_IDLE: begin
				if (accept && cmd.kind == irts_pkg::KIND_WRITE) begin
					mreq.wr_en                 = 1'b1;
					mreq.wr_addr               = irts_pkg::slot_of(cmd.entry_index);
					mreq.wr_data.range_start   = cmd.entry_range_start;
					mreq.wr_data.record_offset = cmd.entry_record_offset;
				end
			end
			irts_pkg::ST_START: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = irts_pkg::slot_of(bad_r ? lo_r : so.mid);
			end
			irts_pkg::ST_STEP: begin
				// The next probe address goes straight to the memory, unregistered.
				si.init      = 1'b0;
				si.left      = left_q;
				si.right     = right_q;
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = irts_pkg::slot_of(so.mid);
			end
			irts_pkg::ST_RESULT: begin
				mreq = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irts_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		case (state_q)
			irts_pkg::ST_START: begin
				left_q  <= lo_r;
				right_q <= hi_r;
				mid_q   <= bad_r ? lo_r : so.mid;
				bad_q   <= bad_r;
			end
			irts_pkg::ST_STEP: begin
				left_q  <= so.left;
				right_q <= so.right;
				mid_q   <= so.mid;
			end
			default: begin
			end
		endcase
		if (load) begin
			res_q.found_index         <= mid_q;
			res_q.found_range_start   <= rd_data.range_start;
			res_q.found_record_offset <= rd_data.record_offset;
			res_q.bad_span            <= bad_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The probe always lies inside the current span.
	a_probe_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == irts_pkg::ST_STEP) |-> (left_q <= mid_q && mid_q <= right_q))
		else $error("search probe outside the span");

	// The search ends only once the midpoint has closed onto the left bound.
	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == irts_pkg::ST_RESULT) |-> (mid_q == left_q))
		else $error("result taken before the search converged");

	// The table is written only between lookups.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr_en |-> (state_q == irts_pkg::ST_IDLE && !mreq.rd_en))
		else $error("table write during a lookup");

	// A result appears only out of the result state.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == irts_pkg::ST_RESULT))
		else $error("result raised outside the result state");

endmodule
